/* hw/rtl/iiee_pkg.sv */
// package for the infix integer expression evaluator
// holds character codes, operator codes, output width and the shared unit request type
// no dependencies
`timescale 1ns / 1ps

package iiee_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int CH_WIDTH        = 8;

    localparam logic [CH_WIDTH-1:0] CH_PLUS   = 8'h2b;
    localparam logic [CH_WIDTH-1:0] CH_MINUS  = 8'h2d;
    localparam logic [CH_WIDTH-1:0] CH_TIMES  = 8'h2a;
    localparam logic [CH_WIDTH-1:0] CH_DIVIDE = 8'h2f;
    localparam logic [CH_WIDTH-1:0] CH_EQUAL  = 8'h3d;
    localparam logic [CH_WIDTH-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE   = 8'h39;

    localparam logic [1:0] OP_PLUS   = 2'd0;
    localparam logic [1:0] OP_MINUS  = 2'd1;
    localparam logic [1:0] OP_TIMES  = 2'd2;
    localparam logic [1:0] OP_DIVIDE = 2'd3;

    typedef struct packed {
        logic start;
        logic is_div;
    } iiee_alu_req_t;

endpackage

/* hw/rtl/iiee_alu.sv */
// shared iterative unit: shift-add multiply and restoring signed division
// one add or subtract per cycle
// depends on iiee_pkg
`timescale 1ns / 1ps

module iiee_alu
    import iiee_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  iiee_alu_req_t          req,
    input  logic [VALUE_WIDTH-1:0] op_a,
    input  logic [VALUE_WIDTH-1:0] op_b,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic [W-1:0]     z_reg, z_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             div_reg, div_next;
    logic             negq_reg, negq_next;

    logic [W:0] add_a;
    logic [W:0] add_b;
    logic [W:0] add_sum;

    // the single adder shared by both operations
    always_comb begin
        if (div_reg) begin
            add_a   = {z_reg, x_reg[W-1]};
            add_b   = {1'b0, y_reg};
            add_sum = add_a + ~add_b + {{W{1'b0}}, 1'b1};
        end else begin
            add_a   = {1'b0, z_reg};
            add_b   = {1'b0, y_reg};
            add_sum = add_a + add_b;
        end
    end

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        div_next  = div_reg;
        negq_next = negq_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            z_next    = '0;
            div_next  = req.is_div;
            negq_next = op_a[W-1] ^ op_b[W-1];
            if (req.is_div) begin
                x_next = op_a[W-1] ? (W'(0) - op_a) : op_a;
                y_next = op_b[W-1] ? (W'(0) - op_b) : op_b;
            end else begin
                x_next = op_b;
                y_next = op_a;
            end
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            if (div_reg) begin
                if (!add_sum[W]) begin
                    z_next = add_sum[W-1:0];
                    x_next = {x_reg[W-2:0], 1'b1};
                end else begin
                    z_next = add_a[W-1:0];
                    x_next = {x_reg[W-2:0], 1'b0};
                end
            end else begin
                if (x_reg[0]) begin
                    z_next = add_sum[W-1:0];
                end
                y_next = {y_reg[W-2:0], 1'b0};
                x_next = {1'b0, x_reg[W-1:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            div_reg  <= 1'b0;
            negq_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            div_reg  <= div_next;
            negq_reg <= negq_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done   = done_reg;
    assign result = !div_reg ? z_reg : (negq_reg ? (W'(0) - x_reg) : x_reg);

endmodule

/* hw/rtl/infix_integer_expression_evaluator.sv */
// top level of the infix integer expression evaluator
// character decoder, term sequencer and output register around the shared unit
// depends on iiee_pkg and iiee_alu
`timescale 1ns / 1ps

// Usage:
//   s_tdata carries one ASCII character per item, s_tlast marks the last
//   character of an expression. Digits build numbers, + - * / are operators
//   with * and / taking precedence, '=' or s_tlast ends the expression.
//   m_tdata carries the 32-bit two's complement result, m_tuser the
//   division-by-zero flag; one result item follows each ended expression.
// Sequencing:
//   a digit, an ignored character or an operator that ends no number is
//   taken in ST_IDLE alone. A number ending under + or - passes ST_COMP and
//   ST_POST, under * or / also ST_WAIT on the shift-add / restoring divide
//   unit (skipped for a zero divisor). Ending an expression adds ST_EMIT
//   to load the output. s_tready is high only while the sequencer is idle.
// Reset and stall:
//   aresetn (synchronous, active low) clears the expression state and drops
//   m_tvalid. The result register holds its item until m_tready; the next
//   expression is taken meanwhile and only a second result waits for it.

module infix_integer_expression_evaluator
    import iiee_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CH_WIDTH-1:0]  s_tdata,   // [7:0] ch
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_WIDTH-1:0] m_tdata,   // [31:0] value
    output logic                 m_tuser    // [0] div_zero
);

    localparam int W = VALUE_WIDTH;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_COMP = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_POST = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [W-1:0]         sum_reg, sum_next;
    logic [W-1:0]         prod_reg, prod_next;
    logic [W-1:0]         acc_reg, acc_next;
    logic [1:0]           pend_reg, pend_next;
    logic [1:0]           newop_reg, newop_next;
    logic                 setop_reg, setop_next;
    logic                 fin_reg, fin_next;
    logic                 act_reg, act_next;
    logic                 neg_reg, neg_next;
    logic                 seen_reg, seen_next;
    logic                 err_reg, err_next;
    logic                 mval_reg, mval_next;
    logic [OUT_WIDTH-1:0] mdata_reg, mdata_next;
    logic                 muser_reg, muser_next;

    logic          is_digit;
    logic          is_op;
    logic          lead_minus;
    logic          finish;
    logic [1:0]    op_code;
    logic [W-1:0]  digit_val;
    logic [W-1:0]  num;
    logic [W-1:0]  total;
    logic [OUT_WIDTH-1:0] total_out;

    iiee_alu_req_t alu_req;
    logic          alu_done;
    logic [W-1:0]  alu_res;

    iiee_alu #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_alu (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (alu_req),
        .op_a   (prod_reg),
        .op_b   (num),
        .done   (alu_done),
        .result (alu_res)
    );

    assign is_digit   = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign is_op      = (s_tdata == CH_PLUS) || (s_tdata == CH_MINUS)
                     || (s_tdata == CH_TIMES) || (s_tdata == CH_DIVIDE);
    assign lead_minus = (s_tdata == CH_MINUS) && !seen_reg;
    assign finish     = s_tlast || (s_tdata == CH_EQUAL);
    assign digit_val  = W'(4'(s_tdata - CH_ZERO));
    assign num        = neg_reg ? (W'(0) - acc_reg) : acc_reg;
    assign total      = sum_reg + prod_reg;
    assign s_tready   = (state_reg == ST_IDLE);

    always_comb begin
        case (s_tdata)
            CH_PLUS:  op_code = OP_PLUS;
            CH_MINUS: op_code = OP_MINUS;
            CH_TIMES: op_code = OP_TIMES;
            default:  op_code = OP_DIVIDE;
        endcase
    end

    generate
        if (W >= OUT_WIDTH) begin : g_out_trunc
            assign total_out = total[OUT_WIDTH-1:0];
        end else begin : g_out_sext
            assign total_out = {{(OUT_WIDTH-W){total[W-1]}}, total};
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        prod_next  = prod_reg;
        acc_next   = acc_reg;
        pend_next  = pend_reg;
        newop_next = newop_reg;
        setop_next = setop_reg;
        fin_next   = fin_reg;
        act_next   = act_reg;
        neg_next   = neg_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;
        alu_req    = '0;

        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    fin_next   = finish;
                    setop_next = 1'b0;
                    newop_next = op_code;
                    if (is_digit) begin
                        acc_next  = {acc_reg[W-4:0], 3'b000} + {acc_reg[W-2:0], 1'b0}
                                  + digit_val;
                        act_next  = 1'b1;
                        seen_next = 1'b1;
                    end
                    if (is_op) begin
                        seen_next = 1'b1;
                        if (lead_minus) begin
                            neg_next = 1'b1;
                        end else if (act_reg) begin
                            setop_next = 1'b1;
                        end else begin
                            pend_next = op_code;
                        end
                    end
                    if ((is_op && !lead_minus && act_reg)
                            || (finish && (act_reg || is_digit))) begin
                        state_next = ST_COMP;
                    end else if (finish) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_COMP: begin
                neg_next = 1'b0;
                case (pend_reg) inside
                    OP_PLUS, OP_MINUS: begin
                        sum_next   = total;
                        prod_next  = (pend_reg == OP_MINUS) ? (W'(0) - num) : num;
                        state_next = ST_POST;
                    end
                    OP_TIMES: begin
                        alu_req.start  = 1'b1;
                        alu_req.is_div = 1'b0;
                        state_next     = ST_WAIT;
                    end
                    default: begin
                        if (num == '0) begin
                            err_next   = 1'b1;
                            state_next = ST_POST;
                        end else begin
                            alu_req.start  = 1'b1;
                            alu_req.is_div = 1'b1;
                            state_next     = ST_WAIT;
                        end
                    end
                endcase
            end
            ST_WAIT: begin
                if (alu_done) begin
                    prod_next  = alu_res;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                acc_next = '0;
                act_next = 1'b0;
                if (setop_reg) begin
                    pend_next = newop_reg;
                end
                state_next = fin_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdata_next = total_out;
                    muser_next = err_reg;
                    sum_next   = '0;
                    prod_next  = '0;
                    acc_next   = '0;
                    pend_next  = OP_PLUS;
                    act_next   = 1'b0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    err_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sum_reg   <= '0;
            prod_reg  <= '0;
            acc_reg   <= '0;
            pend_reg  <= OP_PLUS;
            setop_reg <= 1'b0;
            fin_reg   <= 1'b0;
            act_reg   <= 1'b0;
            neg_reg   <= 1'b0;
            seen_reg  <= 1'b0;
            err_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            prod_reg  <= prod_next;
            acc_reg   <= acc_next;
            pend_reg  <= pend_next;
            setop_reg <= setop_next;
            fin_reg   <= fin_next;
            act_reg   <= act_next;
            neg_reg   <= neg_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
            mval_reg  <= mval_next;
        end
        newop_reg <= newop_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

/* verif/tb_infix_integer_expression_evaluator.sv */
// self-checking testbench for infix_integer_expression_evaluator
// feeds directed and random expressions one character at a time and checks each result
// depends on iiee_pkg and the evaluator rtl
`timescale 1ns / 1ps

module tb_infix_integer_expression_evaluator
    import iiee_pkg::*;
();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1700;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] value;
        logic                 div_zero;
    } expr_result_t;

    class expr_scoreboard;
        logic [31:0]  sum_acc;
        logic [31:0]  term;
        logic [31:0]  num_acc;
        logic [1:0]   pend_op;
        bit           in_number;
        bit           negate_first;
        bit           started;
        bit           div_error;
        expr_result_t results_due[$];
        int           errors;

        function new();
            errors = 0;
            clear_expr();
        endfunction

        function void clear_expr();
            sum_acc      = '0;
            term         = '0;
            num_acc      = '0;
            pend_op      = OP_PLUS;
            in_number    = 1'b0;
            negate_first = 1'b0;
            started      = 1'b0;
            div_error    = 1'b0;
        endfunction

        // signed divide, truncating toward zero, wrapping at 32 bits
        function logic [31:0] trunc_quot(logic [31:0] a, logic [31:0] b);
            logic [31:0] mag_a;
            logic [31:0] mag_b;
            logic [31:0] q;
            mag_a = a[31] ? -a : a;
            mag_b = b[31] ? -b : b;
            q = mag_a / mag_b;
            return (a[31] ^ b[31]) ? -q : q;
        endfunction

        function void close_number();
            logic [31:0] n;
            n = negate_first ? -num_acc : num_acc;
            negate_first = 1'b0;
            case (pend_op)
                OP_PLUS: begin
                    sum_acc = sum_acc + term;
                    term    = n;
                end
                OP_MINUS: begin
                    sum_acc = sum_acc + term;
                    term    = -n;
                end
                OP_TIMES: begin
                    term = term * n;
                end
                default: begin
                    if (n == '0)
                        div_error = 1'b1;
                    else
                        term = trunc_quot(term, n);
                end
            endcase
            num_acc   = '0;
            in_number = 1'b0;
        endfunction

        function void note_input(logic [7:0] c, logic last);
            expr_result_t r;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                num_acc   = num_acc * 32'd10 + 32'(c - CH_ZERO);
                in_number = 1'b1;
                started   = 1'b1;
            end else if (c == CH_PLUS || c == CH_MINUS || c == CH_TIMES || c == CH_DIVIDE) begin
                if (c == CH_MINUS && !started) begin
                    negate_first = 1'b1;
                end else begin
                    if (in_number)
                        close_number();
                    case (c)
                        CH_PLUS:  pend_op = OP_PLUS;
                        CH_MINUS: pend_op = OP_MINUS;
                        CH_TIMES: pend_op = OP_TIMES;
                        default:  pend_op = OP_DIVIDE;
                    endcase
                end
                started = 1'b1;
            end
            if (last || c == CH_EQUAL) begin
                if (in_number)
                    close_number();
                r.value    = sum_acc + term;
                r.div_zero = div_error;
                results_due.push_back(r);
                clear_expr();
            end
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [OUT_WIDTH-1:0] value, logic div_zero);
            expr_result_t want;
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0d", $signed(value)));
            end else begin
                want = results_due.pop_front();
                if (value !== want.value)
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              $signed(value), $signed(want.value)));
                if (div_zero !== want.div_zero)
                    report_mismatch($sformatf("div_zero %b, expected %b",
                                              div_zero, want.div_zero));
            end
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [CH_WIDTH-1:0]  s_tdata  = '0;   // [7:0] ch
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_WIDTH-1:0] m_tdata;         // [31:0] value
    logic                 m_tuser;         // [0] div_zero

    expr_scoreboard board;
    int             send_idle_pct = 18;
    int             recv_idle_pct = 63;
    int             items_counted = 0;
    int             cycles        = 0;

    infix_integer_expression_evaluator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** infix_integer_expression_evaluator: FAILED **");
            $finish;
        end
    end

    // called and returns at a falling edge
    task send_item(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_input(c, last);
        if (last || c == CH_EQUAL || (c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS
            || c == CH_MINUS || c == CH_TIMES || c == CH_DIVIDE)
            items_counted++;
        @(negedge aclk);
    endtask

    task send_expr(input string text, input bit mark_last);
        for (int i = 0; i < text.len(); i++)
            send_item(text[i], mark_last && i == text.len() - 1);
    endtask

    task automatic push_op(ref logic [7:0] text[$]);
        case ($urandom_range(3))
            0:       text.push_back(CH_PLUS);
            1:       text.push_back(CH_MINUS);
            2:       text.push_back(CH_TIMES);
            default: text.push_back(CH_DIVIDE);
        endcase
    endtask

    task automatic send_random_expr();
        logic [7:0] text[$];
        int         n_terms;
        int         n_digits;
        int         ending;
        if ($urandom_range(99) < 80) begin
            if ($urandom_range(3) == 0)
                text.push_back(CH_MINUS);
            n_terms = $urandom_range(1, 6);
            for (int t = 0; t < n_terms; t++) begin
                if (t > 0) begin
                    push_op(text);
                    if ($urandom_range(9) == 0)
                        push_op(text);
                end
                if (text.size() > 0 && text[$] == CH_DIVIDE && $urandom_range(3) == 0) begin
                    text.push_back(CH_ZERO);
                end else begin
                    n_digits = ($urandom_range(9) == 0) ? $urandom_range(8, 12)
                                                       : $urandom_range(1, 3);
                    for (int d = 0; d < n_digits; d++) begin
                        text.push_back(8'(CH_ZERO + $urandom_range(9)));
                        if ($urandom_range(19) == 0)
                            text.push_back(8'h20);
                    end
                end
            end
        end else begin
            // noise: raw bytes, stray digits and operators
            repeat ($urandom_range(0, 8)) begin
                case ($urandom_range(2))
                    0:       text.push_back(8'($urandom_range(255)));
                    1:       text.push_back(8'(CH_ZERO + $urandom_range(9)));
                    default: push_op(text);
                endcase
            end
        end
        // end with '=', with tlast alone, or with both
        ending = $urandom_range(2);
        if (ending != 1)
            text.push_back(CH_EQUAL);
        else if (text.size() == 0)
            text.push_back(8'(CH_ZERO + $urandom_range(9)));
        for (int i = 0; i < text.size(); i++)
            send_item(text[i], ending != 0 && i == text.size() - 1);
    endtask

    initial begin
        board = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_expr("=", 1'b0);
        send_expr("7", 1'b1);
        send_expr("3=", 1'b1);
        send_expr("-5=", 1'b0);
        send_expr("2+3*4=", 1'b0);
        send_expr("10-4/2=", 1'b0);
        send_expr("-7/2=", 1'b0);
        send_expr("7/0+1=", 1'b0);
        send_expr("2+*3=", 1'b0);
        send_expr("*5=", 1'b0);
        send_expr("+5=", 1'b0);
        send_expr("1 2=", 1'b0);
        send_expr("5+=", 1'b0);
        send_expr("4294967295=", 1'b0);
        send_expr("2147483647+1=", 1'b0);
        send_expr("-2147483648/4294967295=", 1'b0);
        send_expr("99999999999*9=", 1'b0);
        send_expr("8a", 1'b1);
        send_expr("0-9=", 1'b0);
        send_expr("--3=", 1'b0);
        send_item(8'hff, 1'b0);
        send_item(CH_EQUAL, 1'b0);

        items_counted = 0;
        while (items_counted < RANDOM_ITEMS) begin
            if (items_counted < RANDOM_ITEMS / 3) begin
                send_idle_pct = 18;
                recv_idle_pct = 63;
            end else if (items_counted < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 18;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_expr();
        end
        s_tvalid <= 1'b0;

        while (board.results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0)
            $display("** infix_integer_expression_evaluator: PASSED **");
        else
            $display("** infix_integer_expression_evaluator: FAILED **");
        $finish;
    end

endmodule
